>>> hw/rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, token codes and tables of the script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned KeywordCharsDefault = 6;
  localparam int unsigned QueueDepth = 4;
  localparam logic [30:0] NumMax = 31'h7fffffff;
  localparam logic [15:0] LenMax = 16'hffff;
  localparam logic [7:0] FracMax = 8'hff;

  localparam logic [5:0] KUnknown = 6'd0;
  localparam logic [5:0] KEof = 6'd1;
  localparam logic [5:0] KId = 6'd2;
  localparam logic [5:0] KInt = 6'd3;
  localparam logic [5:0] KFloat = 6'd4;
  localparam logic [5:0] KStr = 6'd5;
  localparam logic [5:0] KQuo = 6'd6;
  localparam logic [5:0] KCmt = 6'd7;
  localparam logic [5:0] KKw0 = 6'd8;
  localparam logic [5:0] KPunct0 = 6'd19;
  localparam logic [5:0] KOp0 = 6'd26;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_WORD, MODE_NUM, MODE_STR, MODE_CMT, MODE_OP
  } lex_mode_e;

  // one token as it leaves the lexer core
  typedef struct packed {
    logic [5:0]  kind;
    logic [30:0] num;
    logic [7:0]  frac;
    logic [15:0] len;
  } token_t;

  // up to two tokens caused by one byte
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_t;

  function automatic logic is_skip(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic [5:0] single_op(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h3d: k = KOp0 + 6'd0;
      8'h3c: k = KOp0 + 6'd1;
      8'h3e: k = KOp0 + 6'd3;
      8'h2b: k = KOp0 + 6'd9;
      8'h2d: k = KOp0 + 6'd10;
      8'h2a: k = KOp0 + 6'd11;
      8'h2f: k = KOp0 + 6'd12;
      8'h25: k = KOp0 + 6'd13;
      8'h21: k = KOp0 + 6'd14;
      8'h26: k = KOp0 + 6'd15;
      8'h5e: k = KOp0 + 6'd16;
      8'h7c: k = KOp0 + 6'd17;
      8'h7e: k = KOp0 + 6'd18;
      default: k = KUnknown;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_op(input logic [7:0] p, input logic [7:0] c);
    logic [5:0] k;
    k = 6'd0;
    if (p == 8'h3c && c == 8'h3d) k = KOp0 + 6'd2;
    if (p == 8'h3e && c == 8'h3d) k = KOp0 + 6'd4;
    if (p == 8'h3d && c == 8'h3d) k = KOp0 + 6'd5;
    if (p == 8'h21 && c == 8'h3d) k = KOp0 + 6'd6;
    if (p == 8'h7c && c == 8'h7c) k = KOp0 + 6'd7;
    if (p == 8'h26 && c == 8'h26) k = KOp0 + 6'd8;
    if (p == 8'h3e && c == 8'h3e) k = KOp0 + 6'd19;
    if (p == 8'h3c && c == 8'h3c) k = KOp0 + 6'd20;
    return k;
  endfunction

  function automatic logic [6:0] op_prec(input logic [5:0] kind);
    logic [6:0] p;
    case (kind)
      6'd26: p = 7'd35;
      6'd27, 6'd28, 6'd29, 6'd30: p = 7'd42;
      6'd31, 6'd32: p = 7'd41;
      6'd33: p = 7'd36;
      6'd34: p = 7'd37;
      6'd35, 6'd36: p = 7'd44;
      6'd37, 6'd38: p = 7'd45;
      6'd39: p = 7'd46;
      6'd40, 6'd44: p = 7'd48;
      6'd41: p = 7'd40;
      6'd42: p = 7'd39;
      6'd43: p = 7'd38;
      6'd45, 6'd46: p = 7'd43;
      default: p = 7'h7f;
    endcase
    return p;
  endfunction

  // keyword packed as 6 bytes, first character in the low byte
  function automatic logic [5:0] kw_match(input logic [47:0] w, input logic [15:0] n);
    logic [5:0] k;
    k = KId;
    if (n == 16'd4 && w[31:0] == 32'h636e7566) k = KKw0 + 6'd0;
    if (n == 16'd6 && w == 48'h6e7275746572) k = KKw0 + 6'd1;
    if (n == 16'd5 && w[39:0] == 40'h7373616c63) k = KKw0 + 6'd2;
    if (n == 16'd4 && w[31:0] == 32'h666c6573) k = KKw0 + 6'd3;
    if (n == 16'd6 && w == 48'h6e7265747865) k = KKw0 + 6'd4;
    if (n == 16'd2 && w[15:0] == 16'h6669) k = KKw0 + 6'd5;
    if (n == 16'd5 && w[39:0] == 40'h656c696877) k = KKw0 + 6'd6;
    if (n == 16'd3 && w[23:0] == 24'h726f66) k = KKw0 + 6'd7;
    if (n == 16'd2 && w[15:0] == 16'h6e69) k = KKw0 + 6'd8;
    if (n == 16'd4 && w[31:0] == 32'h65736c65) k = KKw0 + 6'd9;
    if (n == 16'd4 && w[31:0] == 32'h66696c65) k = KKw0 + 6'd10;
    return k;
  endfunction

endpackage

>>> hw/rtl/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front
// Classifies each byte, updates lexer state and forms the tokens it causes.
// ----------------------------------------------------------------------------
module stl_front #(
  parameter int unsigned KeywordChars = stl_pkg::KeywordCharsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       ch_i,
  output stl_pkg::step_t   step_o
);
  import stl_pkg::*;

  localparam int unsigned IdxW = $clog2(KeywordChars);

  lex_mode_e   mode_q, mode_d;
  logic [7:0]  pend_q, pend_d;
  logic [7:0]  word_q [KeywordChars];
  logic [15:0] cnt_q, cnt_d;
  logic [30:0] acc_q, acc_d;
  logic [7:0]  frac_q, frac_d;
  logic        pt_q, pt_d;
  logic [47:0] kw_w;
  logic [34:0] mul;
  logic [35:0] acc_sum;
  logic        wr_first, wr_next;

  token_t t_old, t_new;
  logic   h_old, h_new;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      kw_w[i*8 +: 8] = word_q[i];
    end
  end

  assign mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
  assign acc_sum = {1'b0, mul} + {32'd0, ch_i[3:0] - 4'd0};

  function automatic token_t mk(input logic [5:0] k, input logic [30:0] n,
                                input logic [7:0] f, input logic [15:0] l);
    token_t t;
    t.kind = k;
    t.num = n;
    t.frac = f;
    t.len = l;
    return t;
  endfunction

  always_comb begin
    logic restart;
    restart = 1'b0;
    mode_d = mode_q;
    pend_d = pend_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    frac_d = frac_q;
    pt_d = pt_q;
    wr_first = 1'b0;
    wr_next = 1'b0;
    h_old = 1'b0;
    h_new = 1'b0;
    t_old = mk(KUnknown, '0, '0, '0);
    t_new = mk(KUnknown, '0, '0, '0);
    case (mode_q)
      MODE_WORD: begin
        if (is_alpha(ch_i) || is_digit(ch_i)) begin
          wr_next = cnt_q < 16'(KeywordChars);
          if (cnt_q != LenMax) cnt_d = cnt_q + 16'd1;
        end else begin
          h_old = 1'b1;
          t_old = mk(cnt_q > 16'(KeywordChars) ? KId : kw_match(kw_w, cnt_q),
                     '0, '0, cnt_q);
          restart = 1'b1;
        end
      end
      MODE_NUM: begin
        if (is_digit(ch_i)) begin
          acc_d = acc_sum > {5'd0, NumMax} ? NumMax : acc_sum[30:0];
          if (pt_q && frac_q != FracMax) frac_d = frac_q + 8'd1;
        end else if (ch_i == 8'h2e && !pt_q) begin
          pt_d = 1'b1;
        end else begin
          h_old = 1'b1;
          t_old = pt_q ? mk(KFloat, acc_q, frac_q, '0) : mk(KInt, acc_q, '0, '0);
          restart = 1'b1;
        end
      end
      MODE_STR: begin
        if (ch_i == 8'h22) begin
          h_old = 1'b1;
          t_old = mk(KStr, '0, '0, cnt_q);
          mode_d = MODE_IDLE;
        end else if (ch_i == 8'h00) begin
          h_old = 1'b1;
          t_old = mk(KEof, '0, '0, '0);
          mode_d = MODE_IDLE;
        end else if (cnt_q != LenMax) begin
          cnt_d = cnt_q + 16'd1;
        end
      end
      MODE_CMT: begin
        if (ch_i == 8'h00 || ch_i == 8'h0a || ch_i == 8'h0d) begin
          h_old = 1'b1;
          t_old = mk(KCmt, '0, '0, cnt_q);
          restart = 1'b1;
        end else if (cnt_q != LenMax) begin
          cnt_d = cnt_q + 16'd1;
        end
      end
      MODE_OP: begin
        h_old = 1'b1;
        if (pair_op(pend_q, ch_i) != 6'd0) begin
          t_old = mk(pair_op(pend_q, ch_i), '0, '0, '0);
          mode_d = MODE_IDLE;
        end else begin
          t_old = mk(single_op(pend_q), '0, '0, '0);
          restart = 1'b1;
        end
      end
      default: restart = 1'b1;
    endcase
    if (restart) begin
      mode_d = MODE_IDLE;
      if (is_skip(ch_i)) begin
        mode_d = MODE_IDLE;
      end else if (ch_i == 8'h00) begin
        h_new = 1'b1;
        t_new = mk(KEof, '0, '0, '0);
      end else if (is_alpha(ch_i)) begin
        wr_first = 1'b1;
        cnt_d = 16'd1;
        mode_d = MODE_WORD;
      end else if (ch_i == 8'h22) begin
        h_new = 1'b1;
        t_new = mk(KQuo, '0, '0, '0);
        cnt_d = '0;
        mode_d = MODE_STR;
      end else if (is_digit(ch_i) || ch_i == 8'h2e) begin
        pt_d = ch_i == 8'h2e;
        acc_d = is_digit(ch_i) ? {27'd0, ch_i[3:0]} : '0;
        frac_d = '0;
        mode_d = MODE_NUM;
      end else if (ch_i == 8'h23) begin
        cnt_d = '0;
        mode_d = MODE_CMT;
      end else begin
        case (ch_i)
          8'h2c: begin h_new = 1'b1; t_new = mk(KPunct0 + 6'd0, '0, '0, '0); end
          8'h5b: begin h_new = 1'b1; t_new = mk(KPunct0 + 6'd1, '0, '0, '0); end
          8'h5d: begin h_new = 1'b1; t_new = mk(KPunct0 + 6'd2, '0, '0, '0); end
          8'h28: begin h_new = 1'b1; t_new = mk(KPunct0 + 6'd3, '0, '0, '0); end
          8'h29: begin h_new = 1'b1; t_new = mk(KPunct0 + 6'd4, '0, '0, '0); end
          8'h7b: begin h_new = 1'b1; t_new = mk(KPunct0 + 6'd5, '0, '0, '0); end
          8'h7d: begin h_new = 1'b1; t_new = mk(KPunct0 + 6'd6, '0, '0, '0); end
          8'h3d, 8'h3c, 8'h3e, 8'h21, 8'h26, 8'h7c: begin
            pend_d = ch_i;
            mode_d = MODE_OP;
          end
          default: begin h_new = 1'b1; t_new = mk(single_op(ch_i), '0, '0, '0); end
        endcase
      end
    end
  end

  always_comb begin
    step_o.count = {1'b0, h_old} + {1'b0, h_new};
    step_o.tok0 = h_old ? t_old : t_new;
    step_o.tok1 = t_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pend_q <= '0;
      cnt_q <= '0;
      acc_q <= '0;
      frac_q <= '0;
      pt_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      cnt_q <= cnt_d;
      acc_q <= acc_d;
      frac_q <= frac_d;
      pt_q <= pt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && wr_first) begin
      word_q[0] <= ch_i;
    end
    if (step_i && wr_next) begin
      word_q[cnt_q[IdxW-1:0]] <= ch_i;
    end
  end

endmodule

>>> hw/rtl/stl_back.sv
// ----------------------------------------------------------------------------
// stl_back
// Token queue and output: emits each byte's tokens one per cycle if ready_i.
// ----------------------------------------------------------------------------
module stl_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  stl_pkg::step_t step_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [5:0]     token_kind_o,
  output logic [30:0]    num_value_o,
  output logic [7:0]     frac_digits_o,
  output logic [15:0]    text_length_o,
  output logic [6:0]     precedence_o,
  output logic           last_o
);
  import stl_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  token_t         mem_q [QueueDepth];
  logic           lst_q [QueueDepth];
  logic [PtrW-1:0] rd_q, wr_q;
  logic [PtrW:0]  fill_q, fill_d;
  logic           pop;
  logic [PtrW:0]  n_push;

  assign valid_o = fill_q != '0;
  assign pop = valid_o && ready_i;
  assign room_o = (fill_q - {{PtrW{1'b0}}, pop}) <= (PtrW+1)'(QueueDepth - 2);
  assign n_push = push_i ? (PtrW+1)'(step_i.count) : '0;
  assign fill_d = fill_q + n_push - {{PtrW{1'b0}}, pop};

  assign token_kind_o = mem_q[rd_q].kind;
  assign num_value_o = mem_q[rd_q].num;
  assign frac_digits_o = mem_q[rd_q].frac;
  assign text_length_o = mem_q[rd_q].len;
  assign precedence_o = op_prec(mem_q[rd_q].kind);
  assign last_o = lst_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (pop) rd_q <= rd_q + 1'b1;
      wr_q <= wr_q + n_push[PtrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && step_i.count != 2'd0) begin
      mem_q[wr_q] <= step_i.tok0;
      lst_q[wr_q] <= step_i.count == 2'd1;
    end
    if (push_i && step_i.count == 2'd2) begin
      mem_q[wr_q + 1'b1] <= step_i.tok1;
      lst_q[wr_q + 1'b1] <= 1'b1;
    end
  end

endmodule

>>> hw/rtl/script_token_lexer.sv
// Script token lexer: takes one source byte per cycle while the queue has room
// (0 ends the text) and gives identifiers, keywords, numbers, strings, comments,
// punctuation and operators as tokens, each with its precedence. A byte is
// classified in the cycle it is accepted; its zero to two tokens enter a
// four-entry queue and leave one per cycle, so bytes follow back to back while
// the consumer keeps up; a byte that ends one token and starts another gives two.
// ----------------------------------------------------------------------------
// script_token_lexer
// Top level: byte front end and token queue.
// ----------------------------------------------------------------------------
module script_token_lexer #(
  parameter int unsigned KeywordChars = stl_pkg::KeywordCharsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  ch_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [5:0]  token_kind_o,
  output logic [30:0] num_value_o,
  output logic [7:0]  frac_digits_o,
  output logic [15:0] text_length_o,
  output logic [6:0]  precedence_o,
  output logic        last_o
);
  import stl_pkg::*;

  step_t step;
  logic  acc;

  assign acc = valid_i && ready_o;

  stl_front #(.KeywordChars(KeywordChars)) u_front (
    .clk_i, .rst_ni, .step_i(acc), .ch_i, .step_o(step)
  );

  stl_back u_back (
    .clk_i, .rst_ni, .push_i(acc), .step_i(step), .room_o(ready_o),
    .valid_o, .ready_i, .token_kind_o, .num_value_o, .frac_digits_o,
    .text_length_o, .precedence_o, .last_o
  );

`ifndef SYNTH
  a_no_unknown_prec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && token_kind_o < KOp0 |-> precedence_o == 7'h7f) else $error("prec");
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(last_o)) else $error("hold");
  a_two_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && step.count == 2'd2 |-> step.tok1.kind != KId) else $error("two");
`endif

endmodule
